@@ rtl/ema_pkg.sv @@
// shared types, codes and constants of the extent map
package ema_pkg;

	localparam int TABLE_DEPTH_DEF = 256;
	localparam int ADDR_W          = 48;
	localparam int LEN_W           = 32;
	localparam int ELEN_W          = 49;

	// command codes of an input word
	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	// status codes of a result word
	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_MERGED = 2'd1,
		STAT_MISS   = 2'd2,
		STAT_FULL   = 2'd3
	} stat_code_t;

	// kind of result to load into the output register
	typedef enum logic [1:0] {
		RES_ZERO,
		RES_INSERT,
		RES_HIT,
		RES_MISS
	} res_kind_t;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_INS_RD,
		ST_INS_CMP,
		ST_INS_COMMIT,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_HIT_DIFF,
		ST_HIT_SUM,
		ST_DONE
	} state_t;

	// one table row
	typedef struct packed {
		logic [ADDR_W-1:0] file_start;
		logic [ADDR_W-1:0] file_end;
		logic [ADDR_W-1:0] storage_start;
		logic [ADDR_W-1:0] storage_end;
		logic [ADDR_W-1:0] buffer_start;
	} entry_t;

	// commands from controller to datapath
	typedef struct packed {
		logic      rdy;
		logic      srch_init;
		logic      rd_last;
		logic      rd_mid;
		logic      srch_step;
		logic      merge_calc;
		logic      ins_commit;
		logic      tbl_clear;
		logic      hit_diff;
		logic      hit_sum;
		logic      out_load;
		res_kind_t res;
	} dp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic       taken;
		logic [1:0] cmd;
		logic       srch_open;
		logic       end_below;
		logic       start_le;
		logic       out_free;
	} dp_sts_t;

endpackage

@@ rtl/ema_if.sv @@
// request and response channel interfaces of the extent map
interface ema_req_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  cmd;
	logic [ema_pkg::ADDR_W-1:0]  file_offset;
	logic [ema_pkg::ADDR_W-1:0]  storage_offset;
	logic [ema_pkg::LEN_W-1:0]   byte_count;
	logic [ema_pkg::ADDR_W-1:0]  buffer_address;

	modport source (output valid, cmd, file_offset, storage_offset, byte_count,
		buffer_address, input ready);
	modport sink (input valid, cmd, file_offset, storage_offset, byte_count,
		buffer_address, output ready);
endinterface

interface ema_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  status;
	logic                        hit;
	logic [ema_pkg::ADDR_W-1:0]  mapped_address;
	logic [ema_pkg::ELEN_W-1:0]  remaining_bytes;

	modport source (output valid, status, hit, mapped_address, remaining_bytes,
		input ready);
	modport sink (input valid, status, hit, mapped_address, remaining_bytes,
		output ready);
endinterface

@@ rtl/ema_ctrl.sv @@
// controller state machine of the extent map
module ema_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  ema_pkg::dp_sts_t sts,
	output ema_pkg::dp_cmd_t cmd
);

	ema_pkg::state_t    state_q, state_d;
	ema_pkg::res_kind_t res_q, res_d;

	// state and result kind registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ema_pkg::ST_IDLE;
			res_q   <= ema_pkg::RES_ZERO;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		res_d   = res_q;
		cmd     = '0;
		cmd.res = res_q;
		unique case (state_q)
			ema_pkg::ST_IDLE: begin
				cmd.rdy = 1'b1;
				if (sts.taken) state_d = ema_pkg::ST_DISPATCH;
			end
			ema_pkg::ST_DISPATCH: begin
				unique case (sts.cmd)
					ema_pkg::CMD_INSERT: state_d = ema_pkg::ST_INS_RD;
					ema_pkg::CMD_LOOKUP: begin
						cmd.srch_init = 1'b1;
						state_d       = ema_pkg::ST_SRCH_RD;
					end
					ema_pkg::CMD_CLEAR: begin
						cmd.tbl_clear = 1'b1;
						res_d         = ema_pkg::RES_ZERO;
						state_d       = ema_pkg::ST_DONE;
					end
					default: begin
						res_d   = ema_pkg::RES_ZERO;
						state_d = ema_pkg::ST_DONE;
					end
				endcase
			end
			ema_pkg::ST_INS_RD: begin
				cmd.rd_last = 1'b1;
				state_d     = ema_pkg::ST_INS_CMP;
			end
			ema_pkg::ST_INS_CMP: begin
				cmd.merge_calc = 1'b1;
				state_d        = ema_pkg::ST_INS_COMMIT;
			end
			ema_pkg::ST_INS_COMMIT: begin
				cmd.ins_commit = 1'b1;
				res_d          = ema_pkg::RES_INSERT;
				state_d        = ema_pkg::ST_DONE;
			end
			ema_pkg::ST_SRCH_RD: begin
				if (sts.srch_open) begin
					cmd.rd_mid = 1'b1;
					state_d    = ema_pkg::ST_SRCH_CMP;
				end else begin
					res_d   = ema_pkg::RES_MISS;
					state_d = ema_pkg::ST_DONE;
				end
			end
			ema_pkg::ST_SRCH_CMP: begin
				priority if (sts.end_below) begin
					cmd.srch_step = 1'b1;
					state_d       = ema_pkg::ST_SRCH_RD;
				end else if (sts.start_le) begin
					state_d = ema_pkg::ST_HIT_DIFF;
				end else begin
					cmd.srch_step = 1'b1;
					state_d       = ema_pkg::ST_SRCH_RD;
				end
			end
			ema_pkg::ST_HIT_DIFF: begin
				cmd.hit_diff = 1'b1;
				state_d      = ema_pkg::ST_HIT_SUM;
			end
			ema_pkg::ST_HIT_SUM: begin
				cmd.hit_sum = 1'b1;
				res_d       = ema_pkg::RES_HIT;
				state_d     = ema_pkg::ST_DONE;
			end
			ema_pkg::ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ema_pkg::ST_IDLE;
				end
			end
			default: state_d = ema_pkg::ST_IDLE;
		endcase
	end

endmodule

@@ rtl/ema_dp.sv @@
// datapath of the extent map: input word, entry memory, search and result registers
module ema_dp #(
	parameter int TABLE_DEPTH = ema_pkg::TABLE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	ema_req_if.sink          req,
	ema_rsp_if.source        rsp,
	input  ema_pkg::dp_cmd_t cmd,
	output ema_pkg::dp_sts_t sts
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int AW = ema_pkg::ADDR_W;

	ema_pkg::entry_t mem [TABLE_DEPTH];

	// captured input word
	logic [1:0]                   cmd_q;
	logic [AW-1:0]                fo_q, so_q, ba_q;
	logic [ema_pkg::LEN_W-1:0]    bc_q;

	// table state and search window
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   lo_q, hi1_q;
	logic [IW-1:0]   mid_q;
	logic [CW:0]     mid_sum;
	logic [IW-1:0]   mid_w, last_idx, rd_idx;
	logic            rd_en;
	ema_pkg::entry_t rd_q;

	// insert and hit working registers
	logic [AW-1:0] fe_q, se_q, pbuf_next_q, pfile_next_q;
	logic [AW-1:0] diff_q, addr_q, spos_q;
	logic [1:0]    ins_stat_q;
	logic          full, merge_ok, taken;

	// output register
	logic                         out_valid_q;
	logic [1:0]                   out_status_q;
	logic                         out_hit_q;
	logic [AW-1:0]                out_addr_q;
	logic [ema_pkg::ELEN_W-1:0]   out_elen_q;
	logic                         out_free;

	assign req.ready = cmd.rdy;
	assign taken     = req.valid & cmd.rdy;

	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi1_q} - {{CW{1'b0}}, 1'b1};
	assign mid_w    = mid_sum[IW:1];
	assign last_idx = IW'(count_q - CW'(1));
	assign rd_idx   = cmd.rd_last ? last_idx : mid_w;
	assign rd_en    = cmd.rd_last | cmd.rd_mid;

	assign full     = (count_q == CW'(TABLE_DEPTH));
	assign merge_ok = (count_q != '0) && (ba_q == pbuf_next_q) && (fo_q == pfile_next_q);
	assign out_free = ~out_valid_q | rsp.ready;

	assign sts.taken     = taken;
	assign sts.cmd       = cmd_q;
	assign sts.srch_open = (lo_q < hi1_q);
	assign sts.end_below = (rd_q.file_end < fo_q);
	assign sts.start_le  = (rd_q.file_start <= fo_q);
	assign sts.out_free  = out_free;

	// input word capture
	always_ff @(posedge clk) begin
		if (taken) begin
			cmd_q <= req.cmd;
			fo_q  <= req.file_offset;
			so_q  <= req.storage_offset;
			bc_q  <= req.byte_count;
			ba_q  <= req.buffer_address;
		end
	end

	// entry memory, single port with registered read
	always_ff @(posedge clk) begin
		if (rd_en) rd_q <= mem[rd_idx];
		if (cmd.ins_commit && merge_ok) begin
			mem[last_idx] <= '{file_start: rd_q.file_start, file_end: fe_q,
				storage_start: rd_q.storage_start, storage_end: se_q,
				buffer_start: rd_q.buffer_start};
		end else if (cmd.ins_commit && !full) begin
			mem[IW'(count_q)] <= '{file_start: fo_q, file_end: fe_q,
				storage_start: so_q, storage_end: se_q, buffer_start: ba_q};
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.tbl_clear) begin
			count_q <= '0;
		end else if (cmd.ins_commit && !merge_ok && !full) begin
			count_q <= count_q + CW'(1);
		end
	end

	// search window
	always_ff @(posedge clk) begin
		if (cmd.srch_init) begin
			lo_q  <= '0;
			hi1_q <= count_q;
		end else if (cmd.srch_step) begin
			if (sts.end_below) lo_q <= CW'(mid_q) + CW'(1);
			else hi1_q <= CW'(mid_q);
		end
		if (cmd.rd_mid) mid_q <= mid_w;
	end

	// insert arithmetic: ends, continuation of the last entry, status
	always_ff @(posedge clk) begin
		if (cmd.rd_last) begin
			fe_q <= fo_q + {{(AW-ema_pkg::LEN_W){1'b0}}, bc_q} - AW'(1);
			se_q <= so_q + {{(AW-ema_pkg::LEN_W){1'b0}}, bc_q} - AW'(1);
		end
		if (cmd.merge_calc) begin
			pbuf_next_q  <= rd_q.buffer_start + rd_q.storage_end - rd_q.storage_start
				+ AW'(1);
			pfile_next_q <= rd_q.file_end + AW'(1);
		end
		if (cmd.ins_commit) begin
			priority if (merge_ok) ins_stat_q <= ema_pkg::STAT_MERGED;
			else if (full) ins_stat_q <= ema_pkg::STAT_FULL;
			else ins_stat_q <= ema_pkg::STAT_OK;
		end
	end

	// hit translation
	always_ff @(posedge clk) begin
		if (cmd.hit_diff) diff_q <= fo_q - rd_q.file_start;
		if (cmd.hit_sum) begin
			addr_q <= rd_q.buffer_start + diff_q;
			spos_q <= rd_q.storage_start + diff_q;
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_hit_q  <= 1'b0;
			out_addr_q <= '0;
			out_elen_q <= '0;
			unique case (cmd.res)
				ema_pkg::RES_ZERO:   out_status_q <= ema_pkg::STAT_OK;
				ema_pkg::RES_INSERT: out_status_q <= ins_stat_q;
				ema_pkg::RES_MISS:   out_status_q <= ema_pkg::STAT_MISS;
				ema_pkg::RES_HIT: begin
					out_status_q <= ema_pkg::STAT_OK;
					out_hit_q    <= 1'b1;
					out_addr_q   <= addr_q;
					out_elen_q   <= {1'b0, rd_q.storage_end - spos_q}
						+ ema_pkg::ELEN_W'(1);
				end
				default: out_status_q <= ema_pkg::STAT_OK;
			endcase
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.status          = out_status_q;
	assign rsp.hit             = out_hit_q;
	assign rsp.mapped_address  = out_addr_q;
	assign rsp.remaining_bytes = out_elen_q;

	// count never passes the table depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count above table depth");

	// clear empties the table
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tbl_clear |=> count_q == '0)
		else $error("table not empty after clear");

	// an append grows the table by one
	a_append: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_commit && !merge_ok && !full |=> count_q == $past(count_q) + CW'(1))
		else $error("append did not grow the table");

	// a result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> out_free)
		else $error("result word overwritten");

endmodule

@@ rtl/extent_map_append_and_lookup.sv @@
// top level of the extent map: controller and datapath
//
//  channel  dir  payload
//  req      in   cmd, file_offset, storage_offset, byte_count, buffer_address
//  rsp      out  status, hit, mapped_address, remaining_bytes
//
// one word at a time; req is ready only while the controller is idle
// insert reads the last entry, then merges or appends; clear and the unused code
//   go straight to the result; a lookup is a binary search of p probes,
//   p at most ceil(log2(entries + 1)); each probe reads the single-port entry
//   memory with registered read and compares; a hit then translates the address
// the result waits in an output register; a stalled rsp holds the next result
// arst_n empties the table at once; entry contents need no clearing pass
module extent_map_append_and_lookup #(
	parameter int TABLE_DEPTH = ema_pkg::TABLE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ema_req_if.sink   req,
	ema_rsp_if.source rsp
);

	ema_pkg::dp_cmd_t dp_cmd;
	ema_pkg::dp_sts_t dp_sts;

	ema_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (dp_sts),
		.cmd    (dp_cmd)
	);

	ema_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (dp_cmd),
		.sts    (dp_sts)
	);

endmodule
